// ===== rtl/core/bpd_pkg.sv =====
`default_nettype none
package bpd_pkg;
  localparam int Samples = 20;
  localparam int Cells = Samples + 1;
  localparam int CoordW = 16;
  localparam int DistW = 17;
  localparam int WeightW = 17;
  localparam int SampW = 19;
  localparam int D2W = 36;
  localparam int SqrtSteps = 18;
  // Bernstein weight denominator S^3 and its rounding half
  localparam longint WeightDen = longint'(Samples) * Samples * Samples;
  localparam longint WeightHalf = WeightDen / 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [D2W-1:0] d2_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t p0x;
    coord_t p0y;
    coord_t p1x;
    coord_t p1y;
    coord_t p2x;
    coord_t p2y;
    coord_t p3x;
    coord_t p3y;
  } query_t;
endpackage
`default_nettype wire

// ===== rtl/core/bpd_if.sv =====
`default_nettype none
interface bpd_in_if import bpd_pkg::*; ();
  logic   valid;
  logic   ready;
  query_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpd_out_if import bpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bpd_sample_cell.sv =====
`default_nettype none
// One sample of the curve: evaluate, compare with the running minimum, pass on.
module bpd_sample_cell import bpd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire weight_t w0,
  input  wire weight_t w1,
  input  wire weight_t w2,
  input  wire weight_t w3,
  input  wire logic    vld_i,
  input  wire query_t  q_i,
  input  wire logic    first_i,
  input  wire d2_t     best_i,
  output logic         vld_o,
  output query_t       q_o,
  output d2_t          best_o
);
  // stage A registers: weighted terms
  logic signed [33:0] tx_r [4];
  logic signed [33:0] ty_r [4];
  logic                va_r;
  query_t              qa_r;
  d2_t                 besta_r;
  logic signed [35:0] sx, sy;
  logic signed [SampW-1:0] bx, by;
  logic signed [D2W-1:0] dx, dy;
  d2_t d2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en) begin
      va_r  <= vld_i;
      vld_o <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r[0] <= $signed({1'b0, w0}) * q_i.p0x;
      tx_r[1] <= $signed({1'b0, w1}) * q_i.p1x;
      tx_r[2] <= $signed({1'b0, w2}) * q_i.p2x;
      tx_r[3] <= $signed({1'b0, w3}) * q_i.p3x;
      ty_r[0] <= $signed({1'b0, w0}) * q_i.p0y;
      ty_r[1] <= $signed({1'b0, w1}) * q_i.p1y;
      ty_r[2] <= $signed({1'b0, w2}) * q_i.p2y;
      ty_r[3] <= $signed({1'b0, w3}) * q_i.p3y;
      qa_r    <= q_i;
      besta_r <= first_i ? {D2W{1'b1}} : best_i;
      q_o     <= qa_r;
      best_o  <= (d2 < besta_r) ? d2 : besta_r;
    end
  end

  always_comb begin
    sx = 36'(tx_r[0]) + 36'(tx_r[1]) + 36'(tx_r[2]) + 36'(tx_r[3]) + 36'sd32768;
    sy = 36'(ty_r[0]) + 36'(ty_r[1]) + 36'(ty_r[2]) + 36'(ty_r[3]) + 36'sd32768;
    bx = sx[16 +: SampW];
    by = sy[16 +: SampW];
    dx = D2W'(qa_r.px) - D2W'(bx);
    dy = D2W'(qa_r.py) - D2W'(by);
    d2 = dx * dx + dy * dy;
  end
endmodule
`default_nettype wire

// ===== rtl/core/bpd_sqrt_cell.sv =====
`default_nettype none
// One restoring square root step; one result bit enters per cell.
module bpd_sqrt_cell import bpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [4:0]       step,
  input  wire logic             vld_i,
  input  wire d2_t              rem_i,
  input  wire logic [DistW:0]   root_i,
  output logic                  vld_o,
  output d2_t                   rem_o,
  output logic [DistW:0]        root_o
);
  logic [D2W+1:0] trial;
  logic [D2W+1:0] part;

  always_comb begin
    part  = (D2W+2)'(rem_i >> (2 * step));
    trial = (D2W+2)'({root_i, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else if (en) vld_o <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (part >= trial) begin
        rem_o  <= rem_i - (D2W'(trial) << (2 * step));
        root_o <= {root_i[DistW-1:0], 1'b1};
      end else begin
        rem_o  <= rem_i;
        root_o <= {root_i[DistW-1:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bezier_point_distance_unit.sv =====
`default_nettype none
// Sampled distance from a query point to a cubic Bezier curve.
// in:  one transfer carries the query point and the four control points
//      (signed Q12.4). out: one transfer carries distance (unsigned Q13.4),
//      the floor of the square root of the smallest squared distance over
//      21 evenly spaced samples.
// Throughput: one item per cycle while out does not stall. Each query passes
// through the row of sample cells (multiply, then sum/compare), then the 18
// square root cells, one result bit each, then the output register.
// The whole row advances together: when the output register is full and
// out_ready is low, the row holds and in_ready drops; the output register
// lets the last result wait while the row stays full.
// Reset clears all valid bits; no payload is cleared.
module bezier_point_distance_unit import bpd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  bpd_in_if.sink    in_ch,
  bpd_out_if.source out_ch
);
  logic en;
  logic vld   [Cells+1];
  query_t q   [Cells+1];
  d2_t  best  [Cells+1];
  logic sv    [SqrtSteps+1];
  d2_t  rem   [SqrtSteps+1];
  logic [DistW:0] root [SqrtSteps+1];
  logic out_vld_r;
  logic [DistW-1:0] out_dist_r;

  // advance unless a finished result is waiting and blocked
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign vld[0] = in_ch.valid;
  assign q[0] = in_ch.data;
  assign best[0] = '0;

  for (genvar g = 0; g < Cells; g++) begin : g_samp
    // Q1.16 Bernstein weights for this sample, rounded half up
    localparam longint U = longint'(Samples - g);
    localparam longint V = longint'(g);
    localparam weight_t W0 = weight_t'((65536 * U * U * U + WeightHalf) / WeightDen);
    localparam weight_t W1 = weight_t'((3 * 65536 * U * U * V + WeightHalf) / WeightDen);
    localparam weight_t W2 = weight_t'((3 * 65536 * U * V * V + WeightHalf) / WeightDen);
    localparam weight_t W3 = weight_t'((65536 * V * V * V + WeightHalf) / WeightDen);

    bpd_sample_cell u_cell (
      .clk, .rst_n, .en,
      .w0(W0), .w1(W1), .w2(W2), .w3(W3),
      .vld_i(vld[g]), .q_i(q[g]), .first_i(g == 0), .best_i(best[g]),
      .vld_o(vld[g+1]), .q_o(q[g+1]), .best_o(best[g+1])
    );
  end

  assign sv[0] = vld[Cells];
  assign rem[0] = best[Cells];
  assign root[0] = '0;

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_sqrt
    bpd_sqrt_cell u_sq (
      .clk, .rst_n, .en,
      .step(5'(SqrtSteps - 1 - s)),
      .vld_i(sv[s]), .rem_i(rem[s]), .root_i(root[s]),
      .vld_o(sv[s+1]), .rem_o(rem[s+1]), .root_o(root[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= sv[SqrtSteps];
  end

  always_ff @(posedge clk) begin
    if (en) out_dist_r <= root[SqrtSteps][DistW-1:0];
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.distance = out_dist_r;
endmodule
`default_nettype wire

// ===== rtl/core/bpd_checker.sv =====
`default_nettype none
module bpd_checker import bpd_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [DistW-1:0] out_distance
);
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with output empty");
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance))
    else $error("stalled result changed");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance <= 17'd92682) else $error("distance out of range");
endmodule

bind bezier_point_distance_unit bpd_checker u_bpd_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_distance(out_ch.distance)
);
`default_nettype wire

// ===== sim/tb_bezier_point_distance_unit.sv =====
`timescale 1ns / 1ps
module tb_bezier_point_distance_unit import bpd_pkg::*; ();

  logic clk;
  logic rst_n;
  bpd_in_if in_ch ();
  bpd_out_if out_ch ();

  bezier_point_distance_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [DistW-1:0] dist_expected_q[$];
  int err_count;
  bit rand_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint weight_q16(int i, int k);
    longint u;
    longint num;
    longint den;
    u = Samples - i;
    den = longint'(Samples) * Samples * Samples;
    num = ((k == 1 || k == 2) ? 3 : 1) * 65536;
    for (int n = 0; n < 3 - k; n++) num = num * u;
    for (int n = 0; n < k; n++) num = num * i;
    return (num + den / 2) / den;
  endfunction

  function automatic longint round_to_q4(longint acc);
    longint biased;
    biased = acc + (longint'(1) << 40) + 32768;
    return (biased >>> 16) - (longint'(1) << 24);
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [DistW-1:0] min_curve_distance(query_t q);
    longint w[4];
    longint bx;
    longint by;
    longint dx;
    longint dy;
    longint d2;
    longint best;
    best = 0;
    for (int i = 0; i <= Samples; i++) begin
      for (int k = 0; k < 4; k++) w[k] = weight_q16(i, k);
      bx = round_to_q4(w[0] * q.p0x + w[1] * q.p1x + w[2] * q.p2x + w[3] * q.p3x);
      by = round_to_q4(w[0] * q.p0y + w[1] * q.p1y + w[2] * q.p2y + w[3] * q.p3y);
      dx = longint'(q.px) - bx;
      dy = longint'(q.py) - by;
      d2 = dx * dx + dy * dy;
      if (i == 0 || d2 < best) best = d2;
    end
    return DistW'(floor_sqrt(best));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_query(query_t q);
    int gap;
    gap = rand_stall ? gap_len() : 0;
    // drop valid only across a real gap; back to back keeps it high
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    dist_expected_q.insert(dist_expected_q.size(), min_curve_distance(q));
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    if (r < 5) return coord_t'($urandom_range(0, 4095) - 2048);
    return coord_t'($urandom);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    q.px = rand_coord();
    q.py = rand_coord();
    q.p0x = rand_coord();
    q.p1y = rand_coord();
    q.p3x = rand_coord();
    return q;
  endfunction

  task automatic test_extremes();
    query_t q;
    q = '0;
    send_query(q);
    q = '1;
    send_query(q);
    q = {10{16'sh7fff}};
    send_query(q);
    q = {10{16'sh8000}};
    send_query(q);
    // far corner point against a curve at the opposite corner
    q = {16'sh7fff, 16'sh7fff, {8{16'sh8000}}};
    send_query(q);
    q = {16'sh8000, 16'sh8000, {8{16'sh7fff}}};
    send_query(q);
    // alternating extremes push the rounded weight sum past the range
    q = {16'sh0, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
         16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
    send_query(q);
    q = {16'sh7fff, 16'sh8000, {8{16'sh7fff}}};
    send_query(q);
  endtask

  task automatic test_special_shapes();
    query_t q;
    // point on the start, point on the end, degenerate curve (ties)
    q = {16'sd100, 16'sd200, 16'sd100, 16'sd200, 16'sd500, 16'sd900,
         -16'sd300, 16'sd40, 16'sd1000, -16'sd1000};
    send_query(q);
    q = {16'sd1000, -16'sd1000, 16'sd100, 16'sd200, 16'sd500, 16'sd900,
         -16'sd300, 16'sd40, 16'sd1000, -16'sd1000};
    send_query(q);
    q = {16'sd7, -16'sd9, {4{16'sd50, 16'sd60}}};
    send_query(q);
    q = {16'sd0, 16'sd0, -16'sd1600, 16'sd0, -16'sd1600, 16'sd0,
         16'sd1600, 16'sd0, 16'sd1600, 16'sd0};
    send_query(q);
    for (int n = 0; n < 8; n++) send_query(rand_query());
  endtask

  task automatic test_random_back_to_back();
    rand_stall = 1'b0;
    for (int n = 0; n < 300; n++) send_query(rand_query());
    rand_stall = 1'b1;
  endtask

  task automatic test_random_stalls();
    for (int n = 0; n < 1500; n++) send_query(rand_query());
  endtask

  // Sink side: random backpressure, with stretches of none.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!rand_stall) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        hold = gap_len();
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (dist_expected_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual distance %0d", $time, out_ch.distance);
        err_count++;
      end else begin
        if (out_ch.distance !== dist_expected_q[0]) begin
          $display("%0t: distance mismatch, expected %0d actual %0d", $time,
                   dist_expected_q[0], out_ch.distance);
          err_count++;
        end
        void'(dist_expected_q.pop_front());
      end
    end
  end

  initial begin
    #50ms;
    $display("[bezier_point_distance_unit] ERROR");
    $finish;
  end

  initial begin
    int wait_cycles;
    err_count = 0;
    rand_stall = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_shapes();
    test_random_back_to_back();
    test_random_stalls();
    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (dist_expected_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (80) @(posedge clk);
    if (err_count == 0 && dist_expected_q.size() == 0) begin
      $display("[bezier_point_distance_unit] OK");
    end else begin
      $display("[bezier_point_distance_unit] ERROR");
    end
    $finish;
  end
endmodule
